/* hdl/assert_macros.svh */
// Assertion macros for the RTL modules; the datapath module uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, masked while reset is asserted.
`define PRCM_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define PRCM_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  `PRCM_ASSERT(name, clk, rstn, (ante) |-> (cons), msg)

`endif

/* hdl/prcm_pkg.sv */
// Types and constants for the page reference count mapper.
`timescale 1ns / 1ps

package prcm_pkg;

  localparam int unsigned LOG_W     = 5;
  localparam int unsigned OFFS_W    = 24;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned CNT_OUT_W = 16;
  // page numbers stay below (2^24 + 2^17) >> 12, so one bit over the output index
  localparam int unsigned PAGE_W    = 13;
  localparam int unsigned SUM_W     = 26;

  localparam logic [LOG_W-1:0] LOG_MIN   = 5'd12;
  localparam logic [LOG_W-1:0] LOG_MAX   = 5'd16;
  localparam logic [LOG_W-1:0] LOG_RESET = 5'd12;

  localparam logic CMD_REF = 1'b0;
  localparam logic CMD_REL = 1'b1;

  localparam logic [1:0] CHG_NONE  = 2'd0;
  localparam logic [1:0] CHG_MAP   = 2'd1;
  localparam logic [1:0] CHG_UNMAP = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_SAT   = 2'd2;
  localparam logic [1:0] STS_ZERO  = 2'd3;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic setup;
    logic emit_page;
    logic emit_empty;
  } prcm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic span_empty;
    logic last_page;
    logic out_free;
  } prcm_sts_t;

endpackage

/* hdl/prcm_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module prcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/prcm_ctrl.sv */
// Controller FSM: clear pass, item setup and per-page read/update sequencing.
`timescale 1ns / 1ps

module prcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prcm_pkg::prcm_sts_t sts_i,
  output prcm_pkg::prcm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_READ,
    S_CALC,
    S_EMPTY
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        state_d = sts_i.span_empty ? S_EMPTY : S_READ;
      end
      S_READ: begin
        // count word lands in the read register for the next cycle
        state_d = S_CALC;
      end
      S_CALC: begin
        if (sts_i.out_free) begin
          cmd_o.emit_page = 1'b1;
          state_d         = sts_i.last_page ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_stall_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = in_stall_q;

endmodule

/* hdl/prcm_dp.sv */
// Datapath: config register, span math, count memory and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prcm_dp #(
  parameter int unsigned NUM_PAGES  = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prcm_pkg::LOG_W-1:0]           cfg_wdata_i,
  input  logic                                 command_i,
  input  logic [prcm_pkg::OFFS_W-1:0]          byte_offset_i,
  input  logic [prcm_pkg::LEN_W-1:0]           byte_length_i,
  input  prcm_pkg::prcm_cmd_t                  cmd_i,
  output prcm_pkg::prcm_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [prcm_pkg::IDX_W-1:0]           page_index_o,
  output logic [prcm_pkg::CNT_OUT_W-1:0]       new_count_o,
  output logic [1:0]                           map_change_o,
  output logic                                 touched_o,
  output logic [1:0]                           status_o,
  output logic                                 last_of_run_o
);

  localparam int unsigned ADDR_W = $clog2(NUM_PAGES);
  localparam int unsigned PAGE_W = prcm_pkg::PAGE_W;
  localparam int unsigned SUM_W  = prcm_pkg::SUM_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [prcm_pkg::LOG_W-1:0]  lg_q;
  logic [prcm_pkg::LOG_W-1:0]  lg_eff;
  logic                        cmd_q;
  logic [prcm_pkg::OFFS_W-1:0] offs_q;
  logic [prcm_pkg::LEN_W-1:0]  len_q;
  logic [PAGE_W-1:0]           p_q, end_q;
  logic [PAGE_W-1:0]           first_d, end_d;
  logic [SUM_W-1:0]            span_top;
  logic [ADDR_W-1:0]           clr_q;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic                  in_range;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [1:0]            chg_new;
  logic [1:0]            sts_new;

  logic                           out_valid_q;
  logic                           out_free;
  logic [prcm_pkg::IDX_W-1:0]     page_index_q;
  logic [prcm_pkg::CNT_OUT_W-1:0] new_count_q;
  logic [1:0]                     map_change_q;
  logic                           touched_q;
  logic [1:0]                     status_q;
  logic                           last_q;

  // out-of-range settings clamp to the nearest legal page size
  always_comb begin
    priority if (lg_q < prcm_pkg::LOG_MIN) lg_eff = prcm_pkg::LOG_MIN;
    else if (lg_q > prcm_pkg::LOG_MAX)     lg_eff = prcm_pkg::LOG_MAX;
    else                                   lg_eff = lg_q;
  end

  assign span_top = SUM_W'(offs_q) + SUM_W'(len_q)
                  + ((SUM_W'(1) << lg_eff) - SUM_W'(1));
  assign end_d    = PAGE_W'(span_top >> lg_eff);
  assign first_d  = PAGE_W'(offs_q >> lg_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= prcm_pkg::LOG_RESET;
      clr_q <= '0;
    end else begin
      if (cfg_we_i)      lg_q  <= cfg_wdata_i;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q  <= command_i;
      offs_q <= byte_offset_i;
      len_q  <= byte_length_i;
    end
    if (cmd_i.setup) begin
      p_q   <= first_d;
      end_q <= end_d;
    end else if (cmd_i.emit_page) begin
      p_q <= p_q + 1'b1;
    end
  end

  assign in_range = (p_q < PAGE_W'(NUM_PAGES));

  always_comb begin
    cnt_new = ram_rdata;
    chg_new = prcm_pkg::CHG_NONE;
    sts_new = prcm_pkg::STS_OK;
    if (!in_range) begin
      cnt_new = '0;
      sts_new = prcm_pkg::STS_RANGE;
    end else if (cmd_q == prcm_pkg::CMD_REF) begin
      if (ram_rdata == CNT_MAX) begin
        sts_new = prcm_pkg::STS_SAT;
      end else begin
        cnt_new = ram_rdata + 1'b1;
        if (ram_rdata == '0) chg_new = prcm_pkg::CHG_MAP;
      end
    end else begin
      if (ram_rdata == '0) begin
        sts_new = prcm_pkg::STS_ZERO;
      end else begin
        cnt_new = ram_rdata - 1'b1;
        if (ram_rdata == COUNT_BITS'(1)) chg_new = prcm_pkg::CHG_UNMAP;
      end
    end
  end

  assign ram_we    = cmd_i.clr_step || (cmd_i.emit_page && in_range);
  assign ram_waddr = cmd_i.clr_step ? clr_q : p_q[ADDR_W-1:0];
  assign ram_wdata = cmd_i.clr_step ? '0 : cnt_new;

  prcm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (p_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // output word register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_page || cmd_i.emit_empty) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_page) begin
      page_index_q <= p_q[prcm_pkg::IDX_W-1:0];
      new_count_q  <= prcm_pkg::CNT_OUT_W'(cnt_new);
      map_change_q <= chg_new;
      touched_q    <= 1'b1;
      status_q     <= sts_new;
      last_q       <= (PAGE_W'(p_q + 1'b1) == end_q);
    end else if (cmd_i.emit_empty) begin
      page_index_q <= '0;
      new_count_q  <= '0;
      map_change_q <= prcm_pkg::CHG_NONE;
      touched_q    <= 1'b0;
      status_q     <= prcm_pkg::STS_OK;
      last_q       <= 1'b1;
    end
  end

  assign sts_o.clr_done   = (clr_q == ADDR_W'(NUM_PAGES - 1));
  assign sts_o.span_empty = (end_q <= p_q);
  assign sts_o.last_page  = (PAGE_W'(p_q + 1'b1) == end_q);
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign page_index_o  = page_index_q;
  assign new_count_o   = new_count_q;
  assign map_change_o  = map_change_q;
  assign touched_o     = touched_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

  `PRCM_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, cmd_i.emit_page || cmd_i.emit_empty, out_free, "output word overwritten")
  `PRCM_ASSERT_IMPL(a_wr_in_range, clk_i, rst_ni, ram_we && !cmd_i.clr_step, p_q < PAGE_W'(NUM_PAGES), "count write past table")
  `PRCM_ASSERT_IMPL(a_map_is_one, clk_i, rst_ni, out_valid_q && map_change_q == prcm_pkg::CHG_MAP, new_count_q == prcm_pkg::CNT_OUT_W'(1) && status_q == prcm_pkg::STS_OK, "map request without count of one")
  `PRCM_ASSERT_IMPL(a_unmap_is_zero, clk_i, rst_ni, out_valid_q && map_change_q == prcm_pkg::CHG_UNMAP, new_count_q == '0 && status_q == prcm_pkg::STS_OK, "unmap request without count of zero")

endmodule

/* hdl/page_range_refcount_mapper.sv */
// Top level: per-page reference count table driven by byte ranges.
// The first result word is loaded from the calc state, after setup, check and read;
// an empty span emits its word from the empty state instead. Each page is read, then updated;
// a new input is taken only back in idle; a stalled output holds the page update.
// Reset: counts cleared by a pass over all NUM_PAGES entries, input stalled meanwhile;
// log_page_size resets to 12 and is writable during the pass.
`timescale 1ns / 1ps

module page_range_refcount_mapper #(
  parameter int unsigned NUM_PAGES  = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prcm_pkg::LOG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [prcm_pkg::OFFS_W-1:0]    byte_offset_i,
  input  logic [prcm_pkg::LEN_W-1:0]     byte_length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [prcm_pkg::IDX_W-1:0]     page_index_o,
  output logic [prcm_pkg::CNT_OUT_W-1:0] new_count_o,
  output logic [1:0]                     map_change_o,
  output logic                           touched_o,
  output logic [1:0]                     status_o,
  output logic                           last_of_run_o
);

  prcm_pkg::prcm_cmd_t cmd;
  prcm_pkg::prcm_sts_t sts;

  prcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prcm_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .byte_offset_i (byte_offset_i),
    .byte_length_i (byte_length_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .page_index_o  (page_index_o),
    .new_count_o   (new_count_o),
    .map_change_o  (map_change_o),
    .touched_o     (touched_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for page_range_refcount_mapper: per-page count prediction, word checks.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_PAGES   = 256;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned HOT_PAGE    = 200;
  localparam int unsigned OFFS_SPACE  = 32'h0100_0000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [prcm_pkg::LOG_W-1:0]     cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           command_i;
  logic [prcm_pkg::OFFS_W-1:0]    byte_offset_i;
  logic [prcm_pkg::LEN_W-1:0]     byte_length_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [prcm_pkg::IDX_W-1:0]     page_index_o;
  logic [prcm_pkg::CNT_OUT_W-1:0] new_count_o;
  logic [1:0]                     map_change_o;
  logic                           touched_o;
  logic [1:0]                     status_o;
  logic                           last_of_run_o;

  typedef struct {
    logic [prcm_pkg::IDX_W-1:0]     page;
    logic [prcm_pkg::CNT_OUT_W-1:0] count;
    logic [1:0]                     change;
    logic                           touched;
    logic [1:0]                     status;
    logic                           last;
  } page_word_t;

  page_word_t                 pending_words[$];
  page_word_t                 got_word;
  int unsigned                page_use [NUM_PAGES];
  logic [prcm_pkg::LOG_W-1:0] page_log = prcm_pkg::LOG_RESET;

  int unsigned errors        = 0;
  int unsigned ranges_taken  = 0;
  int unsigned words_checked = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycles        = 0;
  int unsigned hold_seq      = 0;
  int unsigned hold_done     = 0;
  bit          idle_on       = 1'b1;

  page_range_refcount_mapper #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .byte_offset_i (byte_offset_i),
    .byte_length_i (byte_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .page_index_o  (page_index_o),
    .new_count_o   (new_count_o),
    .map_change_o  (map_change_o),
    .touched_o     (touched_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    foreach (page_use[i]) page_use[i] = 0;
  end

  // effective page shift, register clamped to the legal range
  function automatic int unsigned page_shift();
    if (page_log < prcm_pkg::LOG_MIN) return prcm_pkg::LOG_MIN;
    if (page_log > prcm_pkg::LOG_MAX) return prcm_pkg::LOG_MAX;
    return page_log;
  endfunction

  // update the count table for one range and queue the words it should produce
  function automatic void account_range(logic cmd, logic [prcm_pkg::OFFS_W-1:0] offs,
                                        logic [prcm_pkg::LEN_W-1:0] len);
    int unsigned sh, o, l, first, stop, p, c;
    page_word_t  w;
    sh    = page_shift();
    o     = offs;
    l     = len;
    first = o >> sh;
    stop  = (o + l + (32'd1 << sh) - 32'd1) >> sh;
    if (stop <= first) begin
      w = '{page: '0, count: '0, change: prcm_pkg::CHG_NONE, touched: 1'b0,
            status: prcm_pkg::STS_OK, last: 1'b1};
      pending_words.push_back(w);
      return;
    end
    for (p = first; p < stop && p < first + 17; p++) begin
      w.page    = p[prcm_pkg::IDX_W-1:0];
      w.count   = '0;
      w.change  = prcm_pkg::CHG_NONE;
      w.touched = 1'b1;
      w.status  = prcm_pkg::STS_OK;
      w.last    = (p + 1 == stop);
      if (p >= NUM_PAGES) begin
        w.status = prcm_pkg::STS_RANGE;
      end else begin
        c = page_use[p];
        if (cmd == prcm_pkg::CMD_REF) begin
          if (c >= COUNT_MAX) begin
            w.status = prcm_pkg::STS_SAT;
          end else begin
            c++;
            if (c == 1) w.change = prcm_pkg::CHG_MAP;
          end
        end else begin
          if (c == 0) begin
            w.status = prcm_pkg::STS_ZERO;
          end else begin
            c--;
            if (c == 0) w.change = prcm_pkg::CHG_UNMAP;
          end
        end
        page_use[p] = c;
        w.count     = c[prcm_pkg::CNT_OUT_W-1:0];
      end
      pending_words.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result checker first, then config and range tracking, all on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word: page_index %0d, new_count %0d",
                 page_index_o, new_count_o);
          errors++;
        end else begin
          got_word = pending_words.pop_front();
          check_field("page_index", got_word.page, page_index_o);
          check_field("new_count", got_word.count, new_count_o);
          check_field("map_change", got_word.change, map_change_o);
          check_field("touched", got_word.touched, touched_o);
          check_field("status", got_word.status, status_o);
          check_field("last_of_run", got_word.last, last_of_run_o);
          words_checked++;
        end
      end
      if (cfg_we_i) page_log = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        account_range(command_i, byte_offset_i, byte_length_i);
        ranges_taken++;
      end
    end
  end

  // receiver side: random short stalls, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_done) begin
        hold_done = hold_seq;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high on return so back-to-back words need no extra edge
  task automatic send_range(logic cmd, logic [prcm_pkg::OFFS_W-1:0] offs,
                            logic [prcm_pkg::LEN_W-1:0] len);
    command_i     <= cmd;
    byte_offset_i <= offs;
    byte_length_i <= len;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_input(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // one edge first so the last accepted word is already queued
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_page_log(logic [prcm_pkg::LOG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_random_range();
    int unsigned sh, psize, span, o, l, pick, lmax;
    logic        cmd;
    sh    = page_shift();
    psize = 1 << sh;
    span  = NUM_PAGES << sh;
    if (span > OFFS_SPACE) span = OFFS_SPACE;
    lmax  = (3 * psize > 65535) ? 65535 : 3 * psize;
    pick  = $urandom_range(0, 99);
    cmd   = ($urandom_range(0, 9) < 6) ? prcm_pkg::CMD_REF : prcm_pkg::CMD_REL;
    if (pick < 55) begin
      // a few hot pages so counts climb and fall through zero
      o = $urandom_range(0, 15) * psize + $urandom_range(0, psize - 1);
      if ($urandom_range(0, 3) == 0) o = o & ~(psize - 1);
      l = $urandom_range(0, lmax);
    end else if (pick < 75) begin
      o = $urandom_range(0, span - 1);
      l = $urandom_range(0, 65535);
    end else if (pick < 88) begin
      o = $urandom();
      l = $urandom();
    end else if (pick < 95) begin
      o = $urandom_range(0, span - 1);
      if ($urandom_range(0, 1) == 1) o = o & ~(psize - 1);
      l = 0;
    end else begin
      // straddle the end of the table
      o = span - psize / 2 + $urandom_range(0, psize);
      l = $urandom_range(0, lmax);
    end
    send_range(cmd, o[prcm_pkg::OFFS_W-1:0], l[prcm_pkg::LEN_W-1:0]);
    if (idle_on && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 3));
  endtask

  task automatic test_basic_ranges();
    send_range(prcm_pkg::CMD_REF, 24'h000000, 16'd0);     // aligned zero length: empty span
    send_range(prcm_pkg::CMD_REF, 24'h000001, 16'd0);     // unaligned zero length, one page
    send_range(prcm_pkg::CMD_REF, 24'h000000, 16'd4096);
    send_range(prcm_pkg::CMD_REL, 24'h000fff, 16'd1);
    send_range(prcm_pkg::CMD_REL, 24'h000000, 16'd1);     // down to zero: unmap
    send_range(prcm_pkg::CMD_REL, 24'h000000, 16'd1);     // release at zero
    send_range(prcm_pkg::CMD_REF, 24'h000fff, 16'hffff);  // widest span
    send_range(prcm_pkg::CMD_REL, 24'h000fff, 16'hffff);
    send_range(prcm_pkg::CMD_REF, 24'h0ff000, 16'd8192);  // last table page then one past it
    send_range(prcm_pkg::CMD_REL, 24'h0ff800, 16'd2048);
    send_range(prcm_pkg::CMD_REL, 24'h100000, 16'd100);
    send_range(prcm_pkg::CMD_REF, 24'hffffff, 16'hffff);  // top of offset space, index wraps
    send_range(prcm_pkg::CMD_REL, 24'hffffff, 16'd0);
    drain();
  endtask

  task automatic test_size_register();
    set_page_log(prcm_pkg::LOG_MAX);
    send_range(prcm_pkg::CMD_REF, 24'h00ffff, 16'hffff);
    send_range(prcm_pkg::CMD_REL, 24'h010000, 16'd0);
    set_page_log(5'd31);                        // clamps to the largest page
    send_range(prcm_pkg::CMD_REF, 24'hff0001, 16'hffff);
    set_page_log(5'd0);                         // clamps to the smallest page
    send_range(prcm_pkg::CMD_REF, 24'h0ff000, 16'd1);
    set_page_log(5'd17);
    send_range(prcm_pkg::CMD_REL, 24'h00ffff, 16'd1);
    set_page_log(5'd11);
    send_range(prcm_pkg::CMD_REF, 24'h000800, 16'h0800);
    set_page_log(5'd14);
    send_range(prcm_pkg::CMD_REL, 24'h003fff, 16'h4001);
    drain();
  endtask

  // one page climbs, shares a span with its neighbor, then falls through zero
  task automatic test_count_climb();
    int unsigned hot_off;
    set_page_log(prcm_pkg::LOG_MIN);
    idle_on = 1'b0;
    hot_off = HOT_PAGE << prcm_pkg::LOG_MIN;
    repeat (10) send_range(prcm_pkg::CMD_REF, hot_off[prcm_pkg::OFFS_W-1:0], 16'd1);
    hot_off = hot_off - 1;                      // neighbor below and the hot page together
    send_range(prcm_pkg::CMD_REF, hot_off[prcm_pkg::OFFS_W-1:0], 16'd2);
    hot_off = hot_off + 1;
    // eleven releases reach zero, the last one is a release at zero
    repeat (12) send_range(prcm_pkg::CMD_REL, hot_off[prcm_pkg::OFFS_W-1:0], 16'd1);
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_seq++;
    repeat (24) send_random_range();
    drain();
  endtask

  task automatic test_random_mix();
    int                         ph;
    logic [prcm_pkg::LOG_W-1:0] lg;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lg = prcm_pkg::LOG_MAX;
        1: lg = 5'd13;
        2: lg = 5'd0;
        3: lg = 5'd15;
        4: lg = 5'd31;
        5: lg = 5'd14;
        default: lg = $urandom_range(0, 31);
      endcase
      set_page_log(lg);
      repeat (18) send_random_range();
    end
    drain();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    set_page_log(prcm_pkg::LOG_MIN);
    repeat (24) send_random_range();
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = prcm_pkg::CMD_REF;
    byte_offset_i = '0;
    byte_length_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ranges();
    test_size_register();
    test_count_climb();
    test_backpressure();
    test_random_mix();
    test_streaming();

    $display("Ran %0d ranges, %0d page words checked, %0d page size writes.",
             ranges_taken, words_checked, cfg_writes);
    $display("Covered empty spans, pages off the table, counts through zero, hold-off.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
